// ===== rtl/htok_pkg.sv =====
// Shared types, codes and character helpers for the HTML tokenizer.
// No dependencies; every other file imports this package.
`default_nettype none

package htok_pkg;

  // Input item: one byte or an end-of-input mark
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  // Result item: one token event
  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] token_byte;
    logic       last;
  } out_item_t;

  // Token kinds
  localparam logic [3:0] K_CHAR         = 4'd0;
  localparam logic [3:0] K_START_BYTE   = 4'd1;
  localparam logic [3:0] K_END_BYTE     = 4'd2;
  localparam logic [3:0] K_START_DONE   = 4'd3;
  localparam logic [3:0] K_END_DONE     = 4'd4;
  localparam logic [3:0] K_COMMENT_BYTE = 4'd5;
  localparam logic [3:0] K_COMMENT_DONE = 4'd6;
  localparam logic [3:0] K_DOCTYPE_BYTE = 4'd7;
  localparam logic [3:0] K_DOCTYPE_DONE = 4'd8;
  localparam logic [3:0] K_EOF          = 4'd9;
  localparam logic [3:0] K_ERROR        = 4'd10;

  // Tokenizer states
  typedef enum logic [3:0] {
    S_DATA                = 4'd0,
    S_TAG_OPEN            = 4'd1,
    S_END_TAG_OPEN        = 4'd2,
    S_TAG_NAME            = 4'd3,
    S_MARKUP_OPEN         = 4'd4,
    S_MARKUP_DASH         = 4'd5,
    S_MARKUP_DOCTYPE      = 4'd6,
    S_COMMENT             = 4'd7,
    S_COMMENT_END_DASH    = 4'd8,
    S_COMMENT_END         = 4'd9,
    S_DOCTYPE             = 4'd10,
    S_BEFORE_DOCTYPE_NAME = 4'd11,
    S_DOCTYPE_NAME        = 4'd12
  } state_t;

  // Characters
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP_D  = 8'h44;

  // Length of the DOCTYPE keyword
  localparam logic [2:0] MATCH_LEN = 3'd7;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_SPACE;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  // Letters of the DOCTYPE keyword, upper case
  function automatic logic [7:0] doctype_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h44;
      3'd1:    ch = 8'h4F;
      3'd2:    ch = 8'h43;
      3'd3:    ch = 8'h54;
      3'd4:    ch = 8'h59;
      3'd5:    ch = 8'h50;
      3'd6:    ch = 8'h45;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Results of one tokenizer step
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } step_out_t;

endpackage

`default_nettype wire

// ===== rtl/htok_step.sv =====
// Tokenizer state machine: state registers and the one-step transition logic.
// Depends on htok_pkg.
`default_nettype none

module htok_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire htok_pkg::in_item_t item,
  output htok_pkg::step_out_t     step
);
  import htok_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] match_r, match_nxt;
  logic       end_tag_r, end_tag_nxt;
  logic [1:0] cnt;
  out_item_t  r0, r1;
  logic [7:0] c;

  assign c = item.in_byte;

  // Hold state between items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_DATA;
      match_r   <= 3'd0;
      end_tag_r <= 1'b0;
    end else if (fire) begin
      state_r   <= state_nxt;
      match_r   <= match_nxt;
      end_tag_r <= end_tag_nxt;
    end
  end

  // Next state and results for one item
  always_comb begin
    state_nxt   = state_r;
    match_nxt   = match_r;
    end_tag_nxt = end_tag_r;
    cnt         = 2'd0;
    r0          = '0;
    r1          = '0;
    if (item.end_of_input) begin
      if (state_r != S_DATA) begin
        r0.token_kind = K_ERROR;
        r1.token_kind = K_EOF;
        cnt           = 2'd2;
      end else begin
        r0.token_kind = K_EOF;
        cnt           = 2'd1;
      end
      state_nxt = S_DATA;
      match_nxt = 3'd0;
    end else begin
      unique case (state_r)
        S_DATA: begin
          if (c == CH_LT) begin
            state_nxt = S_TAG_OPEN;
          end else begin
            r0.token_kind = K_CHAR;
            r0.token_byte = c;
            cnt           = 2'd1;
          end
        end
        S_TAG_OPEN: begin
          if (c == CH_BANG) begin
            state_nxt = S_MARKUP_OPEN;
          end else if (c == CH_SLASH) begin
            state_nxt = S_END_TAG_OPEN;
          end else if (is_letter(c)) begin
            end_tag_nxt   = 1'b0;
            r0.token_kind = K_START_BYTE;
            r0.token_byte = c;
            cnt           = 2'd1;
            state_nxt     = S_TAG_NAME;
          end else begin
            r0.token_kind = K_ERROR;
            cnt           = 2'd1;
            state_nxt     = S_DATA;
            match_nxt     = 3'd0;
          end
        end
        S_END_TAG_OPEN: begin
          if (is_letter(c)) begin
            end_tag_nxt   = 1'b1;
            r0.token_kind = K_END_BYTE;
            r0.token_byte = c;
            cnt           = 2'd1;
            state_nxt     = S_TAG_NAME;
          end else begin
            r0.token_kind = K_ERROR;
            cnt           = 2'd1;
            state_nxt     = S_DATA;
            match_nxt     = 3'd0;
          end
        end
        S_TAG_NAME: begin
          cnt = 2'd1;
          if (c == CH_GT) begin
            r0.token_kind = end_tag_r ? K_END_DONE : K_START_DONE;
            state_nxt     = S_DATA;
          end else begin
            r0.token_kind = end_tag_r ? K_END_BYTE : K_START_BYTE;
            r0.token_byte = c;
          end
        end
        S_MARKUP_OPEN: begin
          if (c == CH_DASH) begin
            state_nxt = S_MARKUP_DASH;
          end else if (to_upper(c) == CH_UP_D) begin
            match_nxt = 3'd1;
            state_nxt = S_MARKUP_DOCTYPE;
          end else begin
            r0.token_kind = K_ERROR;
            cnt           = 2'd1;
            state_nxt     = S_DATA;
            match_nxt     = 3'd0;
          end
        end
        S_MARKUP_DASH: begin
          if (c == CH_DASH) begin
            state_nxt = S_COMMENT;
          end else begin
            r0.token_kind = K_ERROR;
            cnt           = 2'd1;
            state_nxt     = S_DATA;
            match_nxt     = 3'd0;
          end
        end
        S_MARKUP_DOCTYPE: begin
          if (match_r < MATCH_LEN && to_upper(c) == doctype_char(match_r)) begin
            if (match_r + 3'd1 == MATCH_LEN) begin
              match_nxt = 3'd0;
              state_nxt = S_DOCTYPE;
            end else begin
              match_nxt = match_r + 3'd1;
            end
          end else begin
            r0.token_kind = K_ERROR;
            cnt           = 2'd1;
            state_nxt     = S_DATA;
            match_nxt     = 3'd0;
          end
        end
        S_COMMENT: begin
          if (c == CH_DASH) begin
            state_nxt = S_COMMENT_END_DASH;
          end else begin
            r0.token_kind = K_COMMENT_BYTE;
            r0.token_byte = c;
            cnt           = 2'd1;
          end
        end
        S_COMMENT_END_DASH: begin
          if (c == CH_DASH) begin
            state_nxt = S_COMMENT_END;
          end else begin
            r0.token_kind = K_ERROR;
            cnt           = 2'd1;
            state_nxt     = S_DATA;
            match_nxt     = 3'd0;
          end
        end
        S_COMMENT_END: begin
          cnt       = 2'd1;
          state_nxt = S_DATA;
          if (c == CH_GT) begin
            r0.token_kind = K_COMMENT_DONE;
          end else begin
            r0.token_kind = K_ERROR;
            match_nxt     = 3'd0;
          end
        end
        S_DOCTYPE: begin
          if (is_space(c)) begin
            state_nxt = S_BEFORE_DOCTYPE_NAME;
          end else begin
            r0.token_kind = K_ERROR;
            cnt           = 2'd1;
            state_nxt     = S_DATA;
            match_nxt     = 3'd0;
          end
        end
        S_BEFORE_DOCTYPE_NAME: begin
          if (!is_space(c)) begin
            r0.token_kind = K_DOCTYPE_BYTE;
            r0.token_byte = c;
            cnt           = 2'd1;
            state_nxt     = S_DOCTYPE_NAME;
          end
        end
        S_DOCTYPE_NAME: begin
          cnt = 2'd1;
          if (c == CH_GT) begin
            r0.token_kind = K_DOCTYPE_DONE;
            state_nxt     = S_DATA;
          end else begin
            r0.token_kind = K_DOCTYPE_BYTE;
            r0.token_byte = c;
          end
        end
        default: begin
          r0.token_kind = K_ERROR;
          cnt           = 2'd1;
          state_nxt     = S_DATA;
          match_nxt     = 3'd0;
        end
      endcase
    end
    // Flag the final result of this item
    r0.last = (cnt == 2'd1);
    r1.last = (cnt == 2'd2);
  end

  // Drop results when no item moves
  assign step.count = fire ? cnt : 2'd0;
  assign step.res0  = r0;
  assign step.res1  = r1;

endmodule

`default_nettype wire

// ===== rtl/htok_out_fifo.sv =====
// Four-entry result queue: takes up to two results a cycle, hands out one.
// Depends on htok_pkg.
`default_nettype none

module htok_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire htok_pkg::step_out_t push,
  output logic                     room,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output htok_pkg::out_item_t      out_data
);
  import htok_pkg::*;

  localparam logic [2:0] ROOM_MAX = 3'd2;

  out_item_t  mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem_r[rd_ptr_r];
  // Space for two results keeps an end-of-input item from overflowing
  assign room      = (cnt_r <= ROOM_MAX);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.count;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    cnt_nxt    = cnt_r + {1'b0, push.count} - {2'b00, pop};
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push.res1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/html_tokenizer_fsm_unit.sv =====
// HTML tokenizer top level: input register, state machine step, result queue.
// Depends on htok_pkg, htok_step and htok_out_fifo.
//
// Takes one byte (or end-of-input mark) per cycle while the result queue has
// room and streams token events. Each item is held in an input register,
// goes through the combinational tokenizer state machine step and is written
// into a four-entry result queue, from which its results are offered. Throughput
// is one item per cycle while the downstream takes one result per cycle; the
// queue only lets an item through when it has room for two results, which is
// the most any item produces (end of input outside data text: error, then
// end-of-file). An item that produces no result still passes through the step.
`default_nettype none

module html_tokenizer_fsm_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire htok_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output htok_pkg::out_item_t     out_data
);
  import htok_pkg::*;

  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      room;
  logic      fire;
  step_out_t step;

  assign fire     = in_valid_r && room;
  assign in_ready = !in_valid_r || fire;

  // Hold the input item until the step logic takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  htok_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_data_r),
    .step  (step)
  );

  htok_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/htok_checker.sv =====
// Port-level checks for the HTML tokenizer, bound to the top level.
// Depends on htok_pkg and html_tokenizer_fsm_unit.
`default_nettype none

module htok_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire htok_pkg::out_item_t out_data
);
  import htok_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // End-of-file always closes its item
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == K_EOF |-> out_data.last)
    else $error("end-of-file not marked last");

  // Events without a byte carry zero
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == K_START_DONE ||
                  out_data.token_kind == K_END_DONE ||
                  out_data.token_kind == K_COMMENT_DONE ||
                  out_data.token_kind == K_DOCTYPE_DONE ||
                  out_data.token_kind == K_EOF ||
                  out_data.token_kind == K_ERROR)
    |-> out_data.token_byte == 8'd0)
    else $error("byte set on event without byte");

  // An error is never the last result when followed by end-of-file
  a_err_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.token_kind == K_ERROR && !out_data.last
    |=> out_valid && out_data.token_kind == K_EOF)
    else $error("error not followed by end-of-file");

endmodule

bind html_tokenizer_fsm_unit htok_checker u_htok_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
